// ===== sv/itbs_pkg.sv =====
`timescale 1ns / 1ps

package itbs_pkg;

   localparam int TIMER_COUNT = 16;
   localparam int STAMP_W     = 48;
   localparam int INDEX_W     = 4;
   localparam int TOTAL_W     = 63;
   localparam int CALLS_W     = 32;
   localparam int SEL_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int FREE_W      = $clog2(TIMER_COUNT + 1);

   typedef enum logic [1:0] {
      KIND_REGISTER = 2'd0,
      KIND_START    = 2'd1,
      KIND_STOP     = 2'd2,
      KIND_READ     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNKNOWN     = 2'd1,
      STATUS_WRONG_STATE = 2'd2,
      STATUS_FULL        = 2'd3
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [INDEX_W-1:0]   timer_index;
      logic [STAMP_W-1:0]   now_stamp;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   assigned_index;
      logic [TOTAL_W-1:0]   total_ticks;
      logic [STAMP_W-1:0]   min_ticks;
      logic [STAMP_W-1:0]   max_ticks;
      logic [CALLS_W-1:0]   call_count;
      logic                 is_running;
   } rsp_type;

endpackage

// ===== sv/itbs_req_stage.sv =====
`timescale 1ns / 1ps

module itbs_req_stage import itbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [INDEX_W-1:0]   req_timer_index,
   input  logic [STAMP_W-1:0]   req_now_stamp,
   input  logic                 advance,
   output logic                 held_valid,
   output req_type              held_req
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   req_type req_in;

   assign req_ready  = !valid_ff || advance;
   assign held_valid = valid_ff;
   assign held_req   = req_ff;

   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (req_ready) begin
         valid_in = req_valid;
         req_in   = '{kind: kind_type'(req_kind), timer_index: req_timer_index,
                      now_stamp: req_now_stamp};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

endmodule

// ===== sv/itbs_bank.sv =====
`timescale 1ns / 1ps

module itbs_bank import itbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic [TIMER_COUNT-1:0] active_ff;
   logic [TIMER_COUNT-1:0] running_ff;
   logic [STAMP_W-1:0]     start_ff [TIMER_COUNT];
   logic [TOTAL_W-1:0]     total_ff [TIMER_COUNT];
   logic [STAMP_W-1:0]     min_ff   [TIMER_COUNT];
   logic [STAMP_W-1:0]     max_ff   [TIMER_COUNT];
   logic [CALLS_W-1:0]     calls_ff [TIMER_COUNT];
   logic [FREE_W-1:0]      next_free_ff;

   logic [6:0]         index_ext;
   logic               index_ok;
   logic [SEL_W-1:0]   sel;
   logic [SEL_W-1:0]   free_sel;
   logic               table_full;
   logic               sel_active;
   logic               sel_running;
   logic [STAMP_W-1:0] delta;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] total_next;
   logic [STAMP_W-1:0] min_next;
   logic [STAMP_W-1:0] max_next;
   logic [CALLS_W-1:0] calls_next;
   logic               do_register;
   logic               do_start;
   logic               do_stop;

   assign index_ext  = {{(7 - INDEX_W){1'b0}}, req.timer_index};
   assign index_ok   = index_ext < 7'(TIMER_COUNT);
   assign sel        = index_ext[SEL_W-1:0];
   assign table_full = next_free_ff == FREE_W'(TIMER_COUNT);
   assign free_sel   = next_free_ff[SEL_W-1:0];

   assign sel_active  = index_ok && active_ff[sel];
   assign sel_running = running_ff[sel];

   // interval wraps modulo the stamp width
   assign delta = req.now_stamp - start_ff[sel];
   assign sum   = {1'b0, total_ff[sel]} + {{(TOTAL_W + 1 - STAMP_W){1'b0}}, delta};
   assign total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   assign min_next   = (delta < min_ff[sel]) ? delta : min_ff[sel];
   assign max_next   = (delta > max_ff[sel]) ? delta : max_ff[sel];
   assign calls_next = (&calls_ff[sel]) ? calls_ff[sel] : calls_ff[sel] + 1'b1;

   always_comb begin
      rsp         = '0;
      do_register = 1'b0;
      do_start    = 1'b0;
      do_stop     = 1'b0;
      priority if (req.kind == KIND_REGISTER) begin
         if (table_full) begin
            rsp.status = STATUS_FULL;
         end else begin
            do_register        = 1'b1;
            rsp.assigned_index = INDEX_W'(next_free_ff);
            rsp.total_ticks    = total_ff[free_sel];
            rsp.min_ticks      = min_ff[free_sel];
            rsp.max_ticks      = max_ff[free_sel];
            rsp.call_count     = calls_ff[free_sel];
         end
      end else if (!sel_active) begin
         rsp.status = STATUS_UNKNOWN;
      end else begin
         rsp.total_ticks = total_ff[sel];
         rsp.min_ticks   = min_ff[sel];
         rsp.max_ticks   = max_ff[sel];
         rsp.call_count  = calls_ff[sel];
         rsp.is_running  = sel_running;
         unique case (req.kind)
            KIND_START: begin
               if (sel_running) begin
                  rsp = '0;
                  rsp.status = STATUS_WRONG_STATE;
               end else begin
                  do_start       = 1'b1;
                  rsp.call_count = calls_next;
                  rsp.is_running = 1'b1;
               end
            end
            KIND_STOP: begin
               if (!sel_running) begin
                  rsp = '0;
                  rsp.status = STATUS_WRONG_STATE;
               end else begin
                  do_stop         = 1'b1;
                  rsp.total_ticks = total_next;
                  rsp.min_ticks   = min_next;
                  rsp.max_ticks   = max_next;
                  rsp.is_running  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         running_ff   <= '0;
         next_free_ff <= '0;
         for (int i = 0; i < TIMER_COUNT; i++) begin
            start_ff[i] <= '0;
            total_ff[i] <= '0;
            min_ff[i]   <= '1;
            max_ff[i]   <= '0;
            calls_ff[i] <= '0;
         end
      end else if (fire) begin
         if (do_register) begin
            active_ff[free_sel]  <= 1'b1;
            running_ff[free_sel] <= 1'b0;
            next_free_ff         <= next_free_ff + 1'b1;
         end
         if (do_start) begin
            running_ff[sel] <= 1'b1;
            start_ff[sel]   <= req.now_stamp;
            calls_ff[sel]   <= calls_next;
         end
         if (do_stop) begin
            running_ff[sel] <= 1'b0;
            total_ff[sel]   <= total_next;
            min_ff[sel]     <= min_next;
            max_ff[sel]     <= max_next;
         end
      end
   end

endmodule

// ===== sv/itbs_rsp_stage.sv =====
`timescale 1ns / 1ps

module itbs_rsp_stage import itbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rsp_type              rsp_next,
   output logic                 slot_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [INDEX_W-1:0]   rsp_assigned_index,
   output logic [TOTAL_W-1:0]   rsp_total_ticks,
   output logic [STAMP_W-1:0]   rsp_min_ticks,
   output logic [STAMP_W-1:0]   rsp_max_ticks,
   output logic [CALLS_W-1:0]   rsp_call_count,
   output logic                 rsp_is_running
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_assigned_index = rsp_ff.assigned_index;
   assign rsp_total_ticks    = rsp_ff.total_ticks;
   assign rsp_min_ticks      = rsp_ff.min_ticks;
   assign rsp_max_ticks      = rsp_ff.max_ticks;
   assign rsp_call_count     = rsp_ff.call_count;
   assign rsp_is_running     = rsp_ff.is_running;

endmodule

// ===== sv/interval_timer_bank_stats.sv =====
`timescale 1ns / 1ps

// channel   ports                                   direction
// request   req_valid/req_ready, kind, index, stamp  in
// response  rsp_valid/rsp_ready, status and stats    out
//
// one request per cycle while the response is not stalled; a request waits
// in the input register, where the timer table is read, updated and the
// response formed, and then sits in the response register
// synchronous reset clears all timers (minimum to all ones) and the free count
// a stalled response holds the input register, which then takes no new request

module interval_timer_bank_stats import itbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [INDEX_W-1:0]   req_timer_index,
   input  logic [STAMP_W-1:0]   req_now_stamp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [INDEX_W-1:0]   rsp_assigned_index,
   output logic [TOTAL_W-1:0]   rsp_total_ticks,
   output logic [STAMP_W-1:0]   rsp_min_ticks,
   output logic [STAMP_W-1:0]   rsp_max_ticks,
   output logic [CALLS_W-1:0]   rsp_call_count,
   output logic                 rsp_is_running
);

   logic    held_valid;
   req_type held_req;
   logic    slot_free;
   logic    fire;
   rsp_type rsp_next;

   // the held request commits to the table when the response register takes it
   assign fire = held_valid && slot_free;

   itbs_req_stage u_req (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_timer_index (req_timer_index),
      .req_now_stamp   (req_now_stamp),
      .advance         (fire),
      .held_valid      (held_valid),
      .held_req        (held_req)
   );

   itbs_bank u_bank (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (held_req),
      .rsp   (rsp_next)
   );

   itbs_rsp_stage u_rsp (
      .clock              (clock),
      .reset              (reset),
      .load               (fire),
      .rsp_next           (rsp_next),
      .slot_free          (slot_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_assigned_index (rsp_assigned_index),
      .rsp_total_ticks    (rsp_total_ticks),
      .rsp_min_ticks      (rsp_min_ticks),
      .rsp_max_ticks      (rsp_max_ticks),
      .rsp_call_count     (rsp_call_count),
      .rsp_is_running     (rsp_is_running)
   );

endmodule
